// ===== src/blp_pkg.sv =====
// Package for the LED blink pattern sequencer: phase kinds, field widths,
// shared structs and the pattern ROM as a constant lookup function.
// No dependencies.
package blp_pkg;

   localparam int MODE_WIDTH  = 3;
   localparam int PHASE_WIDTH = 3;
   localparam int LEVEL_WIDTH = 16;
   localparam int DUR_WIDTH   = 21;
   localparam int NOW_WIDTH   = 32;

   localparam logic [MODE_WIDTH-1:0]  NUM_MODES      = 3'd6;
   localparam logic [LEVEL_WIDTH-1:0] ON_LEVEL_RESET = 16'd80;

   typedef enum logic [1:0] {
      KIND_END  = 2'd0,
      KIND_LOOP = 2'd1,
      KIND_ON   = 2'd2,
      KIND_OFF  = 2'd3
   } kind_type;

   typedef enum logic {
      OP_TICK     = 1'b0,
      OP_SET_MODE = 1'b1
   } op_type;

   typedef struct packed {
      kind_type               kind;
      logic [DUR_WIDTH-1:0]   duration;
   } phase_type;

   // Sequencer position shared between the top level and the step logic.
   typedef struct packed {
      logic [MODE_WIDTH-1:0]  mode;
      logic [PHASE_WIDTH-1:0] phase;
   } seq_state_type;

   typedef struct packed {
      logic                   written;
      logic [LEVEL_WIDTH-1:0] level;
   } drive_type;

   // Pattern table. Unlisted phases read as END with no duration, and an
   // unknown mode reads the error pattern.
   function automatic phase_type rom_lookup(input logic [MODE_WIDTH-1:0] mode,
                                            input logic [PHASE_WIDTH-1:0] idx);
      phase_type p;
      p = '{kind: KIND_END, duration: '0};
      case (mode)
         3'd1: begin
            case (idx)
               3'd0: p = '{KIND_ON,   21'd100000};
               3'd1: p = '{KIND_OFF,  21'd100000};
               3'd2: p = '{KIND_ON,   21'd100000};
               3'd3: p = '{KIND_OFF,  21'd1700000};
               3'd4: p = '{KIND_LOOP, 21'd0};
               default: p = '{KIND_END, 21'd0};
            endcase
         end
         3'd2: begin
            case (idx)
               3'd0: p = '{KIND_ON,   21'd250000};
               3'd1: p = '{KIND_OFF,  21'd250000};
               3'd2: p = '{KIND_LOOP, 21'd0};
               default: p = '{KIND_END, 21'd0};
            endcase
         end
         3'd3: begin
            case (idx)
               3'd0: p = '{KIND_ON,   21'd200000};
               3'd1: p = '{KIND_OFF,  21'd1800000};
               3'd2: p = '{KIND_LOOP, 21'd0};
               default: p = '{KIND_END, 21'd0};
            endcase
         end
         3'd4: begin
            case (idx)
               3'd0: p = '{KIND_ON,   21'd0};
               default: p = '{KIND_END, 21'd0};
            endcase
         end
         3'd5: begin
            case (idx)
               3'd0: p = '{KIND_ON,   21'd100000};
               3'd1: p = '{KIND_OFF,  21'd100000};
               3'd2: p = '{KIND_ON,   21'd100000};
               3'd3: p = '{KIND_OFF,  21'd100000};
               3'd4: p = '{KIND_ON,   21'd100000};
               3'd5: p = '{KIND_OFF,  21'd500000};
               3'd6: p = '{KIND_LOOP, 21'd0};
               default: p = '{KIND_END, 21'd0};
            endcase
         end
         default: begin
            // Error pattern, also used for modes beyond the table.
            case (idx)
               3'd0: p = '{KIND_ON,   21'd100000};
               3'd1: p = '{KIND_OFF,  21'd100000};
               3'd2: p = '{KIND_LOOP, 21'd0};
               default: p = '{KIND_END, 21'd0};
            endcase
         end
      endcase
      return p;
   endfunction

endpackage

// ===== src/blp_step.sv =====
// Combinational step logic of the blink sequencer: from the registered item
// and the current position, works out the next position, change time and drive.
// Depends on blp_pkg.
module blp_step import blp_pkg::*; #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                   item_op,
   input  logic [MODE_WIDTH-1:0]  item_mode,
   input  logic [NOW_WIDTH-1:0]   item_now,
   input  logic [LEVEL_WIDTH-1:0] on_level,
   input  seq_state_type          state_cur,
   input  logic [TIME_WIDTH-1:0]  change_cur,
   output seq_state_type          state_next,
   output logic [TIME_WIDTH-1:0]  change_next,
   output drive_type              drive
);

   logic [TIME_WIDTH-1:0]  now_t;
   logic [TIME_WIDTH-1:0]  diff;
   phase_type              cur_phase;
   phase_type              sel_phase;
   phase_type              first_phase;
   phase_type              used_phase;
   logic                   do_apply;
   logic [MODE_WIDTH-1:0]  sel_mode;
   logic [PHASE_WIDTH-1:0] sel_idx;
   logic [TIME_WIDTH-1:0]  dur_t;

   assign now_t     = TIME_WIDTH'({{TIME_WIDTH{1'b0}}, item_now});
   assign diff      = now_t - change_cur;
   assign cur_phase = rom_lookup(state_cur.mode, state_cur.phase);

   // Choose which phase is to be applied, if any.
   always_comb begin
      do_apply = 1'b0;
      sel_mode = state_cur.mode;
      sel_idx  = state_cur.phase;
      if (item_op == OP_SET_MODE) begin
         if (item_mode < NUM_MODES && item_mode != state_cur.mode) begin
            do_apply = 1'b1;
            sel_mode = item_mode;
            sel_idx  = '0;
         end
      end else if (cur_phase.kind != KIND_END && !diff[TIME_WIDTH-1]) begin
         do_apply = 1'b1;
         sel_idx  = state_cur.phase + PHASE_WIDTH'(1);
      end
   end

   assign sel_phase   = rom_lookup(sel_mode, sel_idx);
   assign first_phase = rom_lookup(sel_mode, '0);
   assign used_phase  = (sel_phase.kind == KIND_LOOP) ? first_phase : sel_phase;
   assign dur_t       = TIME_WIDTH'({{TIME_WIDTH{1'b0}}, used_phase.duration});

   always_comb begin
      state_next  = state_cur;
      change_next = change_cur;
      drive       = '{written: 1'b0, level: '0};
      if (do_apply) begin
         state_next.mode  = sel_mode;
         state_next.phase = (sel_phase.kind == KIND_LOOP) ? '0 : sel_idx;
         // An END phase leaves the index moved on but applies nothing.
         if (sel_phase.kind != KIND_END) begin
            change_next   = now_t + dur_t;
            drive.written = 1'b1;
            drive.level   = (used_phase.kind == KIND_ON) ? on_level : '0;
         end
      end
   end

endmodule

// ===== src/led_blink_pattern_sequencer.sv =====
// LED blink pattern sequencer, top level. A beat accepted on req_ goes
// through the input and result registers to rsp_. Throughput: one beat a
// cycle while rsp_tready does not stall. Reset (synchronous, active high)
// selects the error pattern at phase 0, clears the change time to zero and
// sets the on level to 80. Depends on blp_pkg and blp_step.
module led_blink_pattern_sequencer import blp_pkg::*; #(
   parameter int TIME_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration write channel: the on level.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [2:0] mode, [34:3] now_time, [39:35] zero
   input  logic        req_tuser,   // [0] operation
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] drive_level
   output logic        rsp_tuser    // [0] drive_written
);

   // The design is two registers deep. The input register holds one accepted
   // beat; the step logic reads it together with the sequencer position and,
   // as the beat moves on, updates the position and fills the result register.
   // Because the position is updated in the same edge as the result, the next
   // beat sees it at once: one beat a cycle while rsp_tready does not stall.

   logic                   in_valid_ff, in_valid_in;
   logic                   in_op_ff,    in_op_in;
   logic [MODE_WIDTH-1:0]  in_mode_ff,  in_mode_in;
   logic [NOW_WIDTH-1:0]   in_now_ff,   in_now_in;

   seq_state_type          state_ff,    state_in;
   logic [TIME_WIDTH-1:0]  change_ff,   change_in;
   logic [LEVEL_WIDTH-1:0] on_level_ff, on_level_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   drive_type              rsp_drive_ff, rsp_drive_in;

   seq_state_type          step_state;
   logic [TIME_WIDTH-1:0]  step_change;
   drive_type              step_drive;
   logic                   advance;
   logic                   fire;

   // The result register can take a new beat when it is empty or being read.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   blp_step #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_step (
      .item_op     (in_op_ff),
      .item_mode   (in_mode_ff),
      .item_now    (in_now_ff),
      .on_level    (on_level_ff),
      .state_cur   (state_ff),
      .change_cur  (change_ff),
      .state_next  (step_state),
      .change_next (step_change),
      .drive       (step_drive)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_op_in    = in_op_ff;
      in_mode_in  = in_mode_ff;
      in_now_in   = in_now_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_op_in    = req_tuser;
         in_mode_in  = req_tdata[2:0];
         in_now_in   = req_tdata[34:3];
      end
   end

   always_comb begin
      state_in     = state_ff;
      change_in    = change_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
      if (fire) begin
         state_in     = step_state;
         change_in    = step_change;
         rsp_drive_in = step_drive;
      end
   end

   // Every write is taken at once; writes are expected only while no beat is
   // in flight, so that each beat sees a single on level.
   assign on_level_in = (csr_valid && csr_ready) ? csr_data : on_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{mode: '0, phase: '0};
         change_ff    <= '0;
         on_level_ff  <= ON_LEVEL_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         change_ff    <= change_in;
         on_level_ff  <= on_level_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_op_ff     <= in_op_in;
      in_mode_ff   <= in_mode_in;
      in_now_ff    <= in_now_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_drive_ff.level;
   assign rsp_tuser  = rsp_drive_ff.written;

endmodule

// ===== test/tb_led_blink_pattern_sequencer.sv =====
// Self-checking testbench for the LED blink pattern sequencer: drives tick and
// mode-change beats, predicts every drive result and checks it field by field.
// Depends on blp_pkg and led_blink_pattern_sequencer.
`timescale 1ns / 1ps

module tb_led_blink_pattern_sequencer import blp_pkg::*; ();

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_CHUNKS = 6;
   localparam int CHUNK_BEATS = 325;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;    // [2:0] mode, [34:3] now_time, [39:35] zero
   logic        req_tuser = 1'b0;  // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [15:0] drive_level
   logic        rsp_tuser;         // [0] drive_written

   led_blink_pattern_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 20 ns period. Inputs move on the falling edge, outputs are sampled on the
   // rising edge, so nothing depends on scheduling order within a time step.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Blink patterns as the sequencer should see them, one row per mode. Rows
   // are padded with END so that any phase index reads something sensible.
   kind_type pattern_kind [0:5][0:7] = '{
      '{KIND_ON, KIND_OFF, KIND_LOOP, KIND_END, KIND_END, KIND_END, KIND_END, KIND_END},
      '{KIND_ON, KIND_OFF, KIND_ON, KIND_OFF, KIND_LOOP, KIND_END, KIND_END, KIND_END},
      '{KIND_ON, KIND_OFF, KIND_LOOP, KIND_END, KIND_END, KIND_END, KIND_END, KIND_END},
      '{KIND_ON, KIND_OFF, KIND_LOOP, KIND_END, KIND_END, KIND_END, KIND_END, KIND_END},
      '{KIND_ON, KIND_END, KIND_END, KIND_END, KIND_END, KIND_END, KIND_END, KIND_END},
      '{KIND_ON, KIND_OFF, KIND_ON, KIND_OFF, KIND_ON, KIND_OFF, KIND_LOOP, KIND_END}
   };
   int unsigned pattern_span [0:5][0:7] = '{
      '{100000, 100000, 0, 0, 0, 0, 0, 0},
      '{100000, 100000, 100000, 1700000, 0, 0, 0, 0},
      '{250000, 250000, 0, 0, 0, 0, 0, 0},
      '{200000, 1800000, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{100000, 100000, 100000, 100000, 100000, 500000, 0, 0}
   };

   // Predicted sequencer state. The mode held here is always a valid one, as
   // unknown modes never get past a mode change.
   logic [2:0]  seq_mode = '0;
   logic [2:0]  seq_phase = '0;
   logic [31:0] seq_change_time = '0;
   logic [15:0] on_level_shadow = ON_LEVEL_RESET;

   drive_type expected_drives[$];
   int        mismatches = 0;
   int        cycle_count = 0;
   int        idle_pct = 0;   // chance of a gap before each request beat
   int        stall_pct = 0;  // chance of the receiver starting a stall
   int        stall_left = 0;

   // Enters the current phase at time now. A LOOP phase sends the pattern
   // back to its first phase, and an END phase writes nothing at all.
   function automatic drive_type enter_phase(logic [31:0] now);
      drive_type result;
      kind_type  kind;
      result = '{written: 1'b0, level: '0};
      kind = pattern_kind[seq_mode][seq_phase];
      if (kind == KIND_END) return result;
      if (kind == KIND_LOOP) begin
         seq_phase = '0;
         kind = pattern_kind[seq_mode][seq_phase];
      end
      seq_change_time = now + pattern_span[seq_mode][seq_phase];
      result.written = 1'b1;
      result.level = (kind == KIND_ON) ? on_level_shadow : 16'd0;
      return result;
   endfunction

   // Works out the drive result of one accepted beat and updates the
   // predicted state. A tick advances once the wrapped difference between
   // now and the change time is not negative; a frozen pattern ignores ticks.
   function automatic drive_type advance_pattern(op_type op, logic [2:0] mode,
                                                 logic [31:0] now);
      drive_type   result;
      logic [31:0] elapsed;
      result = '{written: 1'b0, level: '0};
      if (op == OP_SET_MODE) begin
         if (mode < NUM_MODES && mode != seq_mode) begin
            seq_mode = mode;
            seq_phase = '0;
            result = enter_phase(now);
         end
      end else if (pattern_kind[seq_mode][seq_phase] != KIND_END) begin
         elapsed = now - seq_change_time;
         if (!elapsed[31]) begin
            seq_phase = seq_phase + 3'd1;
            result = enter_phase(now);
         end
      end
      return result;
   endfunction

   // Mostly no gap; when there is one it is usually short, now and then long.
   function automatic int pick_gap(int pct);
      if (pct > 0 && $urandom_range(0, 99) < pct)
         return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      return 0;
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch on %s: expected %0d, got %0d (cycle %0d)",
                  what, want, got, cycle_count);
   endtask

   // Sends one request beat, holding tvalid high straight on from the
   // previous beat when no gap is drawn, and predicts its result once the
   // handshake has happened.
   task automatic send_item(op_type op, logic [2:0] mode, logic [31:0] now);
      int gap;
      gap = pick_gap(idle_pct);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, now, mode};
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      expected_drives.push_back(advance_pattern(op, mode, now));
   endtask

   // A tick placed relative to the predicted change time. The mode field is
   // meaningless on a tick, so it carries random bits.
   task automatic tick_rel(int offset);
      send_item(OP_TICK, 3'($urandom_range(0, 7)), seq_change_time + offset);
   endtask

   // Drops tvalid and waits until every expected result has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_on_level(logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      on_level_shadow = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Directed walk from reset with the reset on level: a tick just short of
   // and exactly on the change time, same-mode and unknown-mode changes, the
   // frozen connected pattern, loops through two patterns across both
   // timestamp wrap points, and the extremes of the signed difference.
   task automatic test_directed_patterns();
      idle_pct = 0;
      stall_pct = 0;
      send_item(OP_TICK, 3'd0, 32'hFFFF_FFFF);
      send_item(OP_TICK, 3'd7, 32'h0000_0000);
      send_item(OP_SET_MODE, 3'd0, 32'd5);
      send_item(OP_SET_MODE, 3'd6, 32'd6);
      send_item(OP_SET_MODE, 3'd7, 32'd7);
      tick_rel(0);
      send_item(OP_SET_MODE, 3'd4, 32'h7FFF_FFFF);
      send_item(OP_TICK, 3'd0, 32'h8000_0000);
      send_item(OP_TICK, 3'd5, 32'h0000_0000);
      send_item(OP_SET_MODE, 3'd5, 32'hFFFF_FFF0);
      repeat (7) tick_rel(0);
      send_item(OP_SET_MODE, 3'd1, 32'h7FFF_0000);
      tick_rel(32'h8000_0000);
      repeat (4) tick_rel($urandom_range(0, 50));
      tick_rel(-1);
      tick_rel(32'h7FFF_FFFF);
      tick_rel(3);
   endtask

   // Each on level, extremes first, is followed by a restart into a pattern
   // whose first phase is ON so that the new level shows on the output.
   task automatic test_on_level_register();
      logic [15:0] levels [5];
      levels = '{16'hFFFF, 16'd0, 16'h8000, 16'd1, 16'($urandom)};
      idle_pct = 20;
      stall_pct = 20;
      foreach (levels[i]) begin
         wait_idle();
         write_on_level(levels[i]);
         send_item(OP_SET_MODE, (seq_mode + 3'd1) % NUM_MODES, $urandom);
         repeat (3) tick_rel($urandom_range(0, 10));
      end
   endtask

   // Random traffic in chunks, each with its own on level and handshake
   // pressure. Most beats are ticks placed near the predicted change time, so
   // that every pattern gets walked round its loop many times; the rest are
   // early ticks, mode changes (unknown and same mode included) and ticks at
   // wholly random timestamps.
   task automatic test_random_traffic();
      int          pick;
      logic [31:0] now;
      for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
         wait_idle();
         case (chunk)
            0: begin
               write_on_level(16'hFFFF);
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               write_on_level(16'd0);
               idle_pct = 35;
               stall_pct = 0;
            end
            2: begin
               write_on_level(16'($urandom));
               idle_pct = 0;
               stall_pct = 35;
            end
            default: begin
               write_on_level(16'($urandom));
               idle_pct = 25;
               stall_pct = 25;
            end
         endcase
         for (int n = 0; n < CHUNK_BEATS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               case ($urandom_range(0, 3))
                  0: now = $urandom;
                  1: now = seq_change_time + $urandom_range(0, 5000);
                  2: now = 32'h7FFF_FFFF - $urandom_range(0, 300000);
                  default: now = 32'hFFFF_FFFF - $urandom_range(0, 300000);
               endcase
               send_item(OP_SET_MODE, 3'($urandom_range(0, 7)), now);
            end else if (pick < 12) begin
               send_item(OP_TICK, 3'($urandom_range(0, 7)), $urandom);
            end else if (pick < 30) begin
               tick_rel(-$urandom_range(1, 100000));
            end else begin
               tick_rel(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2000));
            end
         end
      end
   endtask

   // Receiver: ready by default, with stalls of random length now and then.
   always @(negedge clock) begin
      if (stall_left == 0) stall_left = pick_gap(stall_pct);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every result beat is held against the oldest prediction.
   always @(posedge clock) begin
      drive_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_drives.size() == 0) begin
            report_mismatch("result beat with nothing expected", 0, rsp_tdata);
         end else begin
            want = expected_drives.pop_front();
            if (rsp_tuser !== want.written)
               report_mismatch("drive_written", want.written, rsp_tuser);
            if (rsp_tdata !== want.level)
               report_mismatch("drive_level", want.level, rsp_tdata);
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_patterns();
      test_on_level_register();
      test_random_traffic();
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== led_blink_pattern_sequencer.f =====
src/blp_pkg.sv
src/blp_step.sv
src/led_blink_pattern_sequencer.sv
test/tb_led_blink_pattern_sequencer.sv
